// ===== hdl/pct_pkg.sv =====
package pct_pkg;

   localparam int MAX_PEERS_DEF = 64;

   localparam int FUNC_W     = 2;
   localparam int PEER_IDX_W = 6;
   localparam int PEER_SPACE = 1 << PEER_IDX_W;
   localparam int COORD_W    = 24;
   localparam int RANGE_W    = 24;
   localparam int TICK_W     = 32;
   localparam int KIND_W     = 2;
   localparam int VALUE_W    = 32;
   localparam int SIZE_W     = 7;

   localparam int MUL_W      = 24;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int DIST_W     = PROD_W + 1;

   localparam int COUNT_W    = 32;
   localparam int DUR_TOT_W  = 64;
   localparam int SIZE_TOT_W = 40;
   localparam int ROUND_W    = 32;

   localparam int DIV_NUM_W  = 64;
   localparam int DIV_DEN_W  = 32;

   localparam logic [RANGE_W-1:0] RANGE_RESET = 24'd1000;

   localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ROUND  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_STAT   = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ENDED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SIZE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STAT  = 2'd2;

endpackage

// ===== hdl/pct_mul.sv =====
module pct_mul (
   input  logic                           clock,
   input  logic [pct_pkg::MUL_W-1:0]      op_a,
   input  logic [pct_pkg::MUL_W-1:0]      op_b,
   output logic [pct_pkg::PROD_W-1:0]     prod
);

   logic [pct_pkg::PROD_W-1:0] prod_ff;
   logic [pct_pkg::PROD_W-1:0] prod_in;

   assign prod_in = pct_pkg::PROD_W'(op_a) * pct_pkg::PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== hdl/pct_div.sv =====
module pct_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [pct_pkg::DIV_NUM_W-1:0]     dividend,
   input  logic [pct_pkg::DIV_DEN_W-1:0]     divisor,
   output logic                              done,
   output logic [pct_pkg::DIV_NUM_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(pct_pkg::DIV_NUM_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(pct_pkg::DIV_NUM_W - 1);

   logic                              run_ff;
   logic                              run_in;
   logic                              done_ff;
   logic                              done_in;
   logic [CNT_W-1:0]                  cnt_ff;
   logic [CNT_W-1:0]                  cnt_in;
   logic [pct_pkg::DIV_DEN_W-1:0]     rem_ff;
   logic [pct_pkg::DIV_DEN_W-1:0]     rem_in;
   logic [pct_pkg::DIV_NUM_W-1:0]     quo_ff;
   logic [pct_pkg::DIV_NUM_W-1:0]     quo_in;
   logic [pct_pkg::DIV_DEN_W-1:0]     den_ff;
   logic [pct_pkg::DIV_DEN_W-1:0]     den_in;
   logic [pct_pkg::DIV_DEN_W:0]       shifted;
   logic [pct_pkg::DIV_DEN_W:0]       trial;
   logic                              fits;

   assign shifted = {rem_ff, quo_ff[pct_pkg::DIV_NUM_W-1]};
   assign trial   = shifted - {1'b0, den_ff};
   assign fits    = ~trial[pct_pkg::DIV_DEN_W];

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         den_in = divisor;
      end else if (run_ff) begin
         rem_in = fits ? trial[pct_pkg::DIV_DEN_W-1:0] : shifted[pct_pkg::DIV_DEN_W-1:0];
         quo_in = {quo_ff[pct_pkg::DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/proximity_contact_tracker_top.sv =====
// A peer sample with a valid peer index keeps busy high for three shared-multiplier passes and
// a compare; no new item is taken while busy, and a contact-ended result is registered from
// the compare. An end-of-round item leaves busy low; its result is strobed in the cycle after
// acceptance. A stat report keeps busy high for two 64-step serial divisions and registers its
// result when the second one is done. The receiver cannot stall results. Synchronous reset
// clears contact flags and accumulators and sets the range to 1000; start ticks are kept.
module proximity_contact_tracker_top #(
   parameter int MAX_PEERS = pct_pkg::MAX_PEERS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [pct_pkg::FUNC_W-1:0]         req_func,
   input  logic [pct_pkg::PEER_IDX_W-1:0]     req_peer_index,
   input  logic signed [pct_pkg::COORD_W-1:0] req_own_x,
   input  logic signed [pct_pkg::COORD_W-1:0] req_own_y,
   input  logic signed [pct_pkg::COORD_W-1:0] req_peer_x,
   input  logic signed [pct_pkg::COORD_W-1:0] req_peer_y,
   input  logic [pct_pkg::TICK_W-1:0]         req_now_tick,
   output logic                               rsp_strobe,
   output logic [pct_pkg::KIND_W-1:0]         rsp_kind,
   output logic [pct_pkg::PEER_IDX_W-1:0]     rsp_peer_id,
   output logic [pct_pkg::VALUE_W-1:0]        rsp_primary_value,
   output logic [pct_pkg::VALUE_W-1:0]        rsp_mean_duration,
   output logic [pct_pkg::SIZE_W-1:0]         rsp_mean_size,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pct_pkg::RANGE_W-1:0]        csr_wireless_range
);

   localparam int PEER_DEPTH = (MAX_PEERS < pct_pkg::PEER_SPACE) ? MAX_PEERS
                                                                 : pct_pkg::PEER_SPACE;
   localparam int PEER_AW    = (PEER_DEPTH > 1) ? $clog2(PEER_DEPTH) : 1;

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_SQX       = 9'b000000010,
      S_SQY       = 9'b000000100,
      S_SQR       = 9'b000001000,
      S_CMP       = 9'b000010000,
      S_DIVD_GO   = 9'b000100000,
      S_DIVD_WAIT = 9'b001000000,
      S_DIVS_GO   = 9'b010000000,
      S_DIVS_WAIT = 9'b100000000
   } state_type;

   state_type                             state_ff;
   state_type                             state_in;
   logic [pct_pkg::RANGE_W-1:0]           range_ff;
   logic [pct_pkg::RANGE_W-1:0]           range_in;
   logic [PEER_DEPTH-1:0]                 flag_ff;
   logic [PEER_DEPTH-1:0]                 flag_in;
   logic [pct_pkg::SIZE_W-1:0]            round_nb_ff;
   logic [pct_pkg::SIZE_W-1:0]            round_nb_in;
   logic [pct_pkg::COUNT_W-1:0]           ended_cnt_ff;
   logic [pct_pkg::COUNT_W-1:0]           ended_cnt_in;
   logic [pct_pkg::DUR_TOT_W-1:0]         dur_tot_ff;
   logic [pct_pkg::DUR_TOT_W-1:0]         dur_tot_in;
   logic [pct_pkg::SIZE_TOT_W-1:0]        size_tot_ff;
   logic [pct_pkg::SIZE_TOT_W-1:0]        size_tot_in;
   logic [pct_pkg::ROUND_W-1:0]           round_tot_ff;
   logic [pct_pkg::ROUND_W-1:0]           round_tot_in;
   logic                                  rsp_strobe_ff;
   logic                                  rsp_strobe_in;

   logic [PEER_AW-1:0]                    idx_ff;
   logic [PEER_AW-1:0]                    idx_in;
   logic [pct_pkg::PEER_IDX_W-1:0]        pid_ff;
   logic [pct_pkg::PEER_IDX_W-1:0]        pid_in;
   logic [pct_pkg::TICK_W-1:0]            now_ff;
   logic [pct_pkg::TICK_W-1:0]            now_in;
   logic [pct_pkg::MUL_W-1:0]             dx_ff;
   logic [pct_pkg::MUL_W-1:0]             dx_in;
   logic [pct_pkg::MUL_W-1:0]             dy_ff;
   logic [pct_pkg::MUL_W-1:0]             dy_in;
   logic [pct_pkg::DIST_W-1:0]            dist_ff;
   logic [pct_pkg::DIST_W-1:0]            dist_in;
   logic [pct_pkg::VALUE_W-1:0]           mdur_ff;
   logic [pct_pkg::VALUE_W-1:0]           mdur_in;
   logic [pct_pkg::KIND_W-1:0]            rsp_kind_ff;
   logic [pct_pkg::KIND_W-1:0]            rsp_kind_in;
   logic [pct_pkg::PEER_IDX_W-1:0]        rsp_pid_ff;
   logic [pct_pkg::PEER_IDX_W-1:0]        rsp_pid_in;
   logic [pct_pkg::VALUE_W-1:0]           rsp_prim_ff;
   logic [pct_pkg::VALUE_W-1:0]           rsp_prim_in;
   logic [pct_pkg::VALUE_W-1:0]           rsp_mdur_ff;
   logic [pct_pkg::VALUE_W-1:0]           rsp_mdur_in;
   logic [pct_pkg::SIZE_W-1:0]            rsp_msize_ff;
   logic [pct_pkg::SIZE_W-1:0]            rsp_msize_in;

   logic [pct_pkg::TICK_W-1:0]            start_mem [PEER_DEPTH];
   logic [pct_pkg::TICK_W-1:0]            start_rd_ff;
   logic                                  mem_rd_en;
   logic                                  mem_wr_en;

   logic                                  accept;
   logic                                  idx_ok;
   logic signed [pct_pkg::COORD_W:0]      diff_x;
   logic signed [pct_pkg::COORD_W:0]      diff_y;
   logic signed [pct_pkg::COORD_W:0]      neg_x;
   logic signed [pct_pkg::COORD_W:0]      neg_y;

   logic [pct_pkg::MUL_W-1:0]             mul_a;
   logic [pct_pkg::MUL_W-1:0]             mul_b;
   logic [pct_pkg::PROD_W-1:0]            mul_prod;

   logic                                  div_start;
   logic [pct_pkg::DIV_NUM_W-1:0]         div_dividend;
   logic [pct_pkg::DIV_DEN_W-1:0]         div_divisor;
   logic                                  div_done;
   logic [pct_pkg::DIV_NUM_W-1:0]         div_quotient;

   logic                                  in_range;
   logic [pct_pkg::TICK_W-1:0]            duration;
   logic [pct_pkg::DUR_TOT_W:0]           dur_sum;
   logic [pct_pkg::SIZE_TOT_W:0]          size_sum;

   assign accept = start & (state_ff == S_IDLE);
   assign idx_ok = 32'(req_peer_index) < PEER_DEPTH;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);

   assign diff_x = {req_peer_x[pct_pkg::COORD_W-1], req_peer_x}
                 - {req_own_x[pct_pkg::COORD_W-1], req_own_x};
   assign diff_y = {req_peer_y[pct_pkg::COORD_W-1], req_peer_y}
                 - {req_own_y[pct_pkg::COORD_W-1], req_own_y};
   assign neg_x  = -diff_x;
   assign neg_y  = -diff_y;

   assign in_range = dist_ff <= pct_pkg::DIST_W'(mul_prod);
   assign duration = now_ff - start_rd_ff;
   assign dur_sum  = {1'b0, dur_tot_ff} + (pct_pkg::DUR_TOT_W + 1)'(duration);
   assign size_sum = {1'b0, size_tot_ff} + (pct_pkg::SIZE_TOT_W + 1)'(round_nb_ff);

   always_comb begin
      unique case (state_ff)
         S_SQX: begin
            mul_a = dx_ff;
            mul_b = dx_ff;
         end
         S_SQY: begin
            mul_a = dy_ff;
            mul_b = dy_ff;
         end
         default: begin
            mul_a = range_ff;
            mul_b = range_ff;
         end
      endcase
   end

   pct_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   assign div_start    = (state_ff == S_DIVD_GO) | (state_ff == S_DIVS_GO);
   assign div_dividend = (state_ff == S_DIVS_GO) ? pct_pkg::DIV_NUM_W'(size_tot_ff)
                                                 : dur_tot_ff;
   assign div_divisor  = (state_ff == S_DIVS_GO) ? round_tot_ff : ended_cnt_ff;

   pct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in      = state_ff;
      range_in      = range_ff;
      flag_in       = flag_ff;
      round_nb_in   = round_nb_ff;
      ended_cnt_in  = ended_cnt_ff;
      dur_tot_in    = dur_tot_ff;
      size_tot_in   = size_tot_ff;
      round_tot_in  = round_tot_ff;
      rsp_strobe_in = 1'b0;
      idx_in        = idx_ff;
      pid_in        = pid_ff;
      now_in        = now_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      dist_in       = dist_ff;
      mdur_in       = mdur_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_pid_in    = rsp_pid_ff;
      rsp_prim_in   = rsp_prim_ff;
      rsp_mdur_in   = rsp_mdur_ff;
      rsp_msize_in  = rsp_msize_ff;
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;

      if (csr_valid && csr_ready) begin
         range_in = csr_wireless_range;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in = req_peer_index[PEER_AW-1:0];
               pid_in = req_peer_index;
               now_in = req_now_tick;
               dx_in  = diff_x[pct_pkg::COORD_W] ? neg_x[pct_pkg::MUL_W-1:0]
                                                 : diff_x[pct_pkg::MUL_W-1:0];
               dy_in  = diff_y[pct_pkg::COORD_W] ? neg_y[pct_pkg::MUL_W-1:0]
                                                 : diff_y[pct_pkg::MUL_W-1:0];
               unique case (req_func)
                  pct_pkg::FUNC_SAMPLE: begin
                     if (idx_ok) begin
                        mem_rd_en = 1'b1;
                        state_in  = S_SQX;
                     end
                  end
                  pct_pkg::FUNC_ROUND: begin
                     size_tot_in = size_sum[pct_pkg::SIZE_TOT_W] ? '1
                                 : size_sum[pct_pkg::SIZE_TOT_W-1:0];
                     if (round_tot_ff != '1) begin
                        round_tot_in = round_tot_ff + 1'b1;
                     end
                     round_nb_in   = '0;
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = pct_pkg::KIND_SIZE;
                     rsp_pid_in    = '0;
                     rsp_prim_in   = pct_pkg::VALUE_W'(round_nb_ff);
                     rsp_mdur_in   = '0;
                     rsp_msize_in  = '0;
                  end
                  pct_pkg::FUNC_STAT: begin
                     state_in = S_DIVD_GO;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SQX: begin
            state_in = S_SQY;
         end
         S_SQY: begin
            dist_in  = pct_pkg::DIST_W'(mul_prod);
            state_in = S_SQR;
         end
         S_SQR: begin
            dist_in  = dist_ff + pct_pkg::DIST_W'(mul_prod);
            state_in = S_CMP;
         end
         S_CMP: begin
            state_in = S_IDLE;
            if (in_range) begin
               if (round_nb_ff != '1) begin
                  round_nb_in = round_nb_ff + 1'b1;
               end
               if (!flag_ff[idx_ff]) begin
                  flag_in[idx_ff] = 1'b1;
                  mem_wr_en       = 1'b1;
               end
            end else if (flag_ff[idx_ff]) begin
               flag_in[idx_ff] = 1'b0;
               dur_tot_in      = dur_sum[pct_pkg::DUR_TOT_W] ? '1
                               : dur_sum[pct_pkg::DUR_TOT_W-1:0];
               if (ended_cnt_ff != '1) begin
                  ended_cnt_in = ended_cnt_ff + 1'b1;
               end
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = pct_pkg::KIND_ENDED;
               rsp_pid_in    = pid_ff;
               rsp_prim_in   = duration;
               rsp_mdur_in   = '0;
               rsp_msize_in  = '0;
            end
         end
         S_DIVD_GO: begin
            state_in = S_DIVD_WAIT;
         end
         S_DIVD_WAIT: begin
            if (div_done) begin
               mdur_in  = (ended_cnt_ff == '0) ? '0 : div_quotient[pct_pkg::VALUE_W-1:0];
               state_in = S_DIVS_GO;
            end
         end
         S_DIVS_GO: begin
            state_in = S_DIVS_WAIT;
         end
         S_DIVS_WAIT: begin
            if (div_done) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = pct_pkg::KIND_STAT;
               rsp_pid_in    = '0;
               rsp_prim_in   = ended_cnt_ff;
               rsp_mdur_in   = mdur_ff;
               rsp_msize_in  = (size_tot_ff == '0 || round_tot_ff == '0) ? '0
                             : div_quotient[pct_pkg::SIZE_W-1:0];
               ended_cnt_in  = '0;
               dur_tot_in    = '0;
               size_tot_in   = '0;
               round_tot_in  = '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         range_ff      <= pct_pkg::RANGE_RESET;
         flag_ff       <= '0;
         round_nb_ff   <= '0;
         ended_cnt_ff  <= '0;
         dur_tot_ff    <= '0;
         size_tot_ff   <= '0;
         round_tot_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         range_ff      <= range_in;
         flag_ff       <= flag_in;
         round_nb_ff   <= round_nb_in;
         ended_cnt_ff  <= ended_cnt_in;
         dur_tot_ff    <= dur_tot_in;
         size_tot_ff   <= size_tot_in;
         round_tot_ff  <= round_tot_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pid_ff       <= pid_in;
      now_ff       <= now_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      dist_ff      <= dist_in;
      mdur_ff      <= mdur_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_pid_ff   <= rsp_pid_in;
      rsp_prim_ff  <= rsp_prim_in;
      rsp_mdur_ff  <= rsp_mdur_in;
      rsp_msize_ff <= rsp_msize_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         start_mem[idx_ff] <= now_ff;
      end
      if (mem_rd_en) begin
         start_rd_ff <= start_mem[req_peer_index[PEER_AW-1:0]];
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_peer_id       = rsp_pid_ff;
   assign rsp_primary_value = rsp_prim_ff;
   assign rsp_mean_duration = rsp_mdur_ff;
   assign rsp_mean_size     = rsp_msize_ff;

`ifndef ASSERT_OFF
   a_ended_after_compare: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_kind == pct_pkg::KIND_ENDED) |-> $past(state_ff == S_CMP))
      else $error("Contact-ended result without a preceding range compare.");

   a_round_result_next: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == pct_pkg::FUNC_ROUND)
         |=> (rsp_strobe && rsp_kind == pct_pkg::KIND_SIZE))
      else $error("End-of-round transaction did not produce its result.");

   a_means_only_in_stats: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_kind != pct_pkg::KIND_STAT)
         |-> (rsp_mean_duration == '0 && rsp_mean_size == '0))
      else $error("Mean fields are nonzero outside a stat report.");

   a_div_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIVD_WAIT || state_ff == S_DIVS_WAIT))
      else $error("Divider finished while the sequencer was not waiting for it.");
`endif

endmodule

// ===== sim/tb.sv =====
module tb;

   localparam int PEERS = pct_pkg::MAX_PEERS_DEF;
   localparam logic [pct_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES = 150;
   localparam int PHASE_ITEMS = 175;

   typedef struct packed {
      logic [pct_pkg::FUNC_W-1:0]     func;
      logic [pct_pkg::PEER_IDX_W-1:0] peer_index;
      logic [pct_pkg::COORD_W-1:0]    own_x;
      logic [pct_pkg::COORD_W-1:0]    own_y;
      logic [pct_pkg::COORD_W-1:0]    peer_x;
      logic [pct_pkg::COORD_W-1:0]    peer_y;
      logic [pct_pkg::TICK_W-1:0]     now_tick;
   } req_type;

   typedef struct packed {
      logic [pct_pkg::KIND_W-1:0]     kind;
      logic [pct_pkg::PEER_IDX_W-1:0] peer_id;
      logic [pct_pkg::VALUE_W-1:0]    primary_value;
      logic [pct_pkg::VALUE_W-1:0]    mean_duration;
      logic [pct_pkg::SIZE_W-1:0]     mean_size;
   } rsp_type;

   class contact_ledger;
      int peers;
      logic [pct_pkg::RANGE_W-1:0] reach;
      bit in_contact[pct_pkg::PEER_SPACE];
      logic [pct_pkg::TICK_W-1:0] since[pct_pkg::PEER_SPACE];
      logic [pct_pkg::SIZE_W-1:0] round_count;
      logic [pct_pkg::COUNT_W-1:0] ended;
      logic [pct_pkg::DUR_TOT_W-1:0] dur_sum;
      logic [pct_pkg::SIZE_TOT_W-1:0] size_sum;
      logic [pct_pkg::ROUND_W-1:0] rounds;
      rsp_type due_reports[$];
      int mismatches;
      int requests;
      int reports;
      int kind_seen[3];

      function new(int n);
         peers = n;
         reach = pct_pkg::RANGE_RESET;
         foreach (in_contact[i]) in_contact[i] = 1'b0;
         round_count = '0;
         ended = '0;
         dur_sum = '0;
         size_sum = '0;
         rounds = '0;
         mismatches = 0;
         requests = 0;
         reports = 0;
         foreach (kind_seen[i]) kind_seen[i] = 0;
      endfunction

      function void set_range(logic [pct_pkg::RANGE_W-1:0] v);
         reach = v;
      endfunction

      function int pending();
         return due_reports.size();
      endfunction

      function void note_request(req_type r);
         longint dx;
         longint dy;
         longint dist_sq;
         longint lim;
         logic [pct_pkg::TICK_W-1:0] dur;
         logic [pct_pkg::SIZE_TOT_W:0] grown;
         logic [pct_pkg::DUR_TOT_W-1:0] q64;
         logic [pct_pkg::SIZE_TOT_W-1:0] q40;
         rsp_type e;
         requests++;
         e = '0;
         case (r.func)
            pct_pkg::FUNC_SAMPLE: begin
               if (int'(r.peer_index) >= peers) return;
               dx = longint'($signed(r.peer_x)) - longint'($signed(r.own_x));
               dy = longint'($signed(r.peer_y)) - longint'($signed(r.own_y));
               if (dx < 0) dx = -dx;
               if (dy < 0) dy = -dy;
               dist_sq = dx * dx + dy * dy;
               lim = longint'(reach) * longint'(reach);
               if (dist_sq <= lim) begin
                  if (round_count != 7'd127) round_count++;
                  if (!in_contact[r.peer_index]) begin
                     in_contact[r.peer_index] = 1'b1;
                     since[r.peer_index] = r.now_tick;
                  end
                  return;
               end
               if (!in_contact[r.peer_index]) return;
               dur = r.now_tick - since[r.peer_index];
               in_contact[r.peer_index] = 1'b0;
               if (dur_sum > ~64'd0 - {32'd0, dur}) dur_sum = '1;
               else dur_sum = dur_sum + {32'd0, dur};
               if (ended != '1) ended++;
               e.kind = pct_pkg::KIND_ENDED;
               e.peer_id = r.peer_index;
               e.primary_value = dur;
            end
            pct_pkg::FUNC_ROUND: begin
               grown = {1'b0, size_sum} + {34'd0, round_count};
               size_sum = grown[pct_pkg::SIZE_TOT_W] ? '1 : grown[pct_pkg::SIZE_TOT_W-1:0];
               if (rounds != '1) rounds++;
               e.kind = pct_pkg::KIND_SIZE;
               e.primary_value = {25'd0, round_count};
               round_count = '0;
            end
            pct_pkg::FUNC_STAT: begin
               e.kind = pct_pkg::KIND_STAT;
               e.primary_value = ended;
               if (ended != 0) begin
                  q64 = dur_sum / {32'd0, ended};
                  e.mean_duration = q64[31:0];
               end
               if (size_sum != 0 && rounds != 0) begin
                  q40 = size_sum / {8'd0, rounds};
                  e.mean_size = q40[pct_pkg::SIZE_W-1:0];
               end
               ended = '0;
               dur_sum = '0;
               size_sum = '0;
               rounds = '0;
            end
            default: return;
         endcase
         due_reports = {due_reports, e};
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("mismatch: %s", what);
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("report %0d %s is %0h, %0h was due",
               reports, name, got, want));
      endtask

      task check_report(rsp_type got);
         rsp_type e;
         reports++;
         if (got.kind <= pct_pkg::KIND_STAT) kind_seen[int'(got.kind)]++;
         if (due_reports.size() == 0) begin
            report_mismatch($sformatf("report %0d of kind %0d arrived with none outstanding",
               reports, got.kind));
            return;
         end
         e = due_reports.pop_front();
         compare_field("kind", 32'(got.kind), 32'(e.kind));
         compare_field("peer_id", 32'(got.peer_id), 32'(e.peer_id));
         compare_field("primary_value", got.primary_value, e.primary_value);
         compare_field("mean_duration", got.mean_duration, e.mean_duration);
         compare_field("mean_size", 32'(got.mean_size), 32'(e.mean_size));
      endtask
   endclass

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [pct_pkg::FUNC_W-1:0] req_func = '0;
   logic [pct_pkg::PEER_IDX_W-1:0] req_peer_index = '0;
   logic signed [pct_pkg::COORD_W-1:0] req_own_x = '0;
   logic signed [pct_pkg::COORD_W-1:0] req_own_y = '0;
   logic signed [pct_pkg::COORD_W-1:0] req_peer_x = '0;
   logic signed [pct_pkg::COORD_W-1:0] req_peer_y = '0;
   logic [pct_pkg::TICK_W-1:0] req_now_tick = '0;
   logic rsp_strobe;
   logic [pct_pkg::KIND_W-1:0] rsp_kind;
   logic [pct_pkg::PEER_IDX_W-1:0] rsp_peer_id;
   logic [pct_pkg::VALUE_W-1:0] rsp_primary_value;
   logic [pct_pkg::VALUE_W-1:0] rsp_mean_duration;
   logic [pct_pkg::SIZE_W-1:0] rsp_mean_size;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [pct_pkg::RANGE_W-1:0] csr_wireless_range = '0;

   contact_ledger ledger;
   int sent = 0;
   int range_writes = 0;
   int quiet = 0;
   logic [pct_pkg::RANGE_W-1:0] reach_now = pct_pkg::RANGE_RESET;
   logic [pct_pkg::TICK_W-1:0] tick_now = 32'd0;

   proximity_contact_tracker_top #(
      .MAX_PEERS(PEERS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_peer_index(req_peer_index),
      .req_own_x(req_own_x),
      .req_own_y(req_own_y),
      .req_peer_x(req_peer_x),
      .req_peer_y(req_peer_y),
      .req_now_tick(req_now_tick),
      .rsp_strobe(rsp_strobe),
      .rsp_kind(rsp_kind),
      .rsp_peer_id(rsp_peer_id),
      .rsp_primary_value(rsp_primary_value),
      .rsp_mean_duration(rsp_mean_duration),
      .rsp_mean_size(rsp_mean_size),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wireless_range(csr_wireless_range)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            ledger.check_report({rsp_kind, rsp_peer_id, rsp_primary_value,
               rsp_mean_duration, rsp_mean_size});
         if (start && !busy)
            ledger.note_request({req_func, req_peer_index, req_own_x, req_own_y,
               req_peer_x, req_peer_y, req_now_tick});
         if (csr_valid && csr_ready) begin
            ledger.set_range(csr_wireless_range);
            range_writes++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", quiet);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic req_type item(logic [pct_pkg::FUNC_W-1:0] f, int idx, int ox, int oy,
                                    int px, int py, logic [pct_pkg::TICK_W-1:0] tick);
      req_type r;
      r.func = f;
      r.peer_index = idx[pct_pkg::PEER_IDX_W-1:0];
      r.own_x = ox[pct_pkg::COORD_W-1:0];
      r.own_y = oy[pct_pkg::COORD_W-1:0];
      r.peer_x = px[pct_pkg::COORD_W-1:0];
      r.peer_y = py[pct_pkg::COORD_W-1:0];
      r.now_tick = tick;
      return r;
   endfunction

   function automatic req_type command(logic [pct_pkg::FUNC_W-1:0] f);
      return item(f, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   function automatic req_type make_sample(bit near, int reach);
      int ox;
      int oy;
      int dx;
      int dy;
      int h;
      int m;
      int idx;
      ox = $urandom_range(0, 1) ? int'($urandom) : int'($urandom_range(0, 4000)) - 2000;
      oy = $urandom_range(0, 1) ? int'($urandom) : int'($urandom_range(0, 4000)) - 2000;
      h = reach / 2;
      m = $urandom_range(0, 99);
      if (near) begin
         if (m < 70) begin
            dx = int'($urandom_range(0, 2 * h)) - h;
            dy = int'($urandom_range(0, 2 * h)) - h;
         end else begin
            dx = reach;
            dy = 0;
         end
      end else if (m < 60) begin
         dx = reach + 1 + int'($urandom_range(0, reach));
         dy = int'($urandom_range(0, 2 * reach)) - reach;
      end else if (m < 80) begin
         dx = reach + 1;
         dy = 0;
      end else begin
         dx = int'($urandom) - ox;
         dy = int'($urandom) - oy;
      end
      if ($urandom_range(0, 1)) dx = -dx;
      if ($urandom_range(0, 1)) dy = -dy;
      if ($urandom_range(0, 1)) begin
         m = dx;
         dx = dy;
         dy = m;
      end
      idx = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 9) : $urandom_range(0, 63);
      return item(pct_pkg::FUNC_SAMPLE, idx, ox, oy, ox + dx, oy + dy, tick_now);
   endfunction

   task automatic send(input req_type r);
      if (!(sent >= 450 && sent < 650) && $urandom_range(0, 99) < 7) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= r.func;
      req_peer_index <= r.peer_index;
      req_own_x <= r.own_x;
      req_own_y <= r.own_y;
      req_peer_x <= r.peer_x;
      req_peer_y <= r.peer_y;
      req_now_tick <= r.now_tick;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_range(input logic [pct_pkg::RANGE_W-1:0] v);
      settle();
      csr_valid <= 1'b1;
      csr_wireless_range <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      reach_now = v;
   endtask

   task automatic directed_items();
      send(item(pct_pkg::FUNC_SAMPLE, 0, 0, 0, 600, 800, 32'd100));
      send(item(pct_pkg::FUNC_SAMPLE, 0, 0, 0, 600, 801, 32'd300));
      send(item(pct_pkg::FUNC_SAMPLE, 63, -8388608, -8388608, -8387608, -8388608,
         32'hFFFF_FFF0));
      send(item(pct_pkg::FUNC_SAMPLE, 63, 8388607, 8388607, -8388608, -8388608,
         32'h0000_0010));
      send(item(pct_pkg::FUNC_SAMPLE, 5, 0, 0, 1001, 0, 32'd50));
      send(item(pct_pkg::FUNC_SAMPLE, 5, 0, 0, 0, -1000, 32'd0));
      send(item(pct_pkg::FUNC_SAMPLE, 5, 100, 100, 100, 100, 32'hFFFF_FFFF));
      send(item(pct_pkg::FUNC_SAMPLE, 5, 0, 0, 0, -1001, 32'd7));
      send(command(FUNC_UNUSED));
      send(command(pct_pkg::FUNC_ROUND));
      send(command(pct_pkg::FUNC_ROUND));
      send(command(pct_pkg::FUNC_STAT));
      send(command(pct_pkg::FUNC_ROUND));
      send(command(pct_pkg::FUNC_STAT));
      send(command(pct_pkg::FUNC_STAT));
   endtask

   task automatic random_phase(input int phase, input int quota);
      int made;
      int n;
      int near_pct;
      int pick;
      bit drained;
      req_type r;
      made = 0;
      drained = 1'b0;
      while (made < quota) begin
         if ($urandom_range(0, 99) < 4) begin
            send(command(pct_pkg::FUNC_STAT));
            made++;
         end else begin
            n = (phase == 3 && made == 0) ? 130 : $urandom_range(1, 24);
            near_pct = (n == 130) ? 100 : 60;
            repeat (n) begin
               pick = $urandom_range(0, 99);
               if (pick < 2) r = command(FUNC_UNUSED);
               else if (pick < 6) r = command(pct_pkg::FUNC_W'($urandom_range(0, 3)));
               else r = make_sample($urandom_range(0, 99) < near_pct, int'(reach_now));
               if ($urandom_range(0, 99) < 3) tick_now = $urandom;
               else tick_now = tick_now + $urandom_range(0, 400);
               send(r);
               if (r.func != FUNC_UNUSED) made++;
            end
            send(command(pct_pkg::FUNC_ROUND));
            made++;
            if ((phase == 2 && !drained) || $urandom_range(0, 99) < 3) begin
               settle();
               drained = 1'b1;
            end
         end
      end
   endtask

   initial begin
      ledger = new(PEERS);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      directed_items();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: write_range(24'd0);
            2: write_range(24'hFF_FFFF);
            3: write_range(pct_pkg::RANGE_W'($urandom_range(1, 5000)));
            4: begin
               write_range(24'd1);
               tick_now = 32'hFFFF_F000;
            end
            5: write_range(pct_pkg::RANGE_W'($urandom_range(5000, 2000000)));
            default: ;
         endcase
         random_phase(phase, PHASE_ITEMS);
      end
      start <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d transactions and %0d range writes across six range settings.",
         ledger.requests, range_writes);
      $display("Checked %0d contact ends, %0d round sizes and %0d stat reports; %0d mismatches.",
         ledger.kind_seen[0], ledger.kind_seen[1], ledger.kind_seen[2], ledger.mismatches);
      if (ledger.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
hdl/pct_pkg.sv
hdl/pct_mul.sv
hdl/pct_div.sv
hdl/proximity_contact_tracker_top.sv
sim/tb.sv
